// File: src/nsrc_pkg.sv
`default_nettype none
package nsrc_pkg;

    // Field and state widths
    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 12;
    localparam int COUNT_W   = 24;
    localparam int PHASE_W   = 32;
    localparam int FRAC_W    = 8;
    localparam int OFFSET_W  = 10;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    // Chunk geometry
    localparam int CHUNK_LEN = 1024;
    localparam int CHUNK_W   = $clog2(CHUNK_LEN);

    // Most outputs per source sample and the smallest usable step
    localparam int MAX_RUN   = 16;
    localparam int RUN_W     = $clog2(MAX_RUN + 1);
    localparam int MIN_STEP  = 16;

    // Register reset values
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(256);
    localparam logic               WIDE_RESET  = 1'b1;
    localparam logic [COUNT_W-1:0] TOTAL_RESET = '0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TOTAL = 2'd2;

    // 8-bit samples are re-centered around zero
    localparam logic [7:0] BYTE_BIAS = 8'h80;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // latch sample, apply sound restart
        logic gen;        // form one output into the hold stage, advance state
        logic push;       // move hold stage into the output register
        logic push_last;  // pushed output closes the run of this sample
        logic finish;     // advance the source index
    } nsrc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic more;       // count not reached and phase is due
        logic out_free;   // output register can take a transaction
    } nsrc_status_t;

endpackage
`default_nettype wire

// File: src/nsrc_ctrl.sv
`default_nettype none
module nsrc_ctrl
    import nsrc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire nsrc_status_t status,
    output nsrc_cmd_t         cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             hold_reg, hold_next;
    logic             more;

    assign in_ready = (state_reg == S_IDLE);
    assign more     = status.more && (run_reg < RUN_W'(MAX_RUN));

    // Sequencing of one source sample
    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        hold_next  = hold_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    run_next   = '0;
                    hold_next  = 1'b0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (more)
                begin
                    // a new output proves the held one is not the last
                    if (!hold_reg || status.out_free)
                    begin
                        cmd.push  = hold_reg;
                        cmd.gen   = 1'b1;
                        run_next  = run_reg + 1'b1;
                        hold_next = 1'b1;
                    end
                end
                else if (!hold_reg || status.out_free)
                begin
                    cmd.push      = hold_reg;
                    cmd.push_last = hold_reg;
                    cmd.finish    = 1'b1;
                    hold_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= '0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            hold_reg  <= hold_next;
        end
    end

endmodule
`default_nettype wire

// File: src/nsrc_dp.sv
`default_nettype none
module nsrc_dp
    import nsrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [SAMPLE_W-1:0]   source_bits,
    input  wire logic                  start_sound,
    input  wire nsrc_cmd_t             cmd,
    output nsrc_status_t               status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [SAMPLE_W-1:0] pcm_value,
    output logic [OFFSET_W-1:0]        chunk_offset,
    output logic                       chunk_begin,
    output logic                       run_last,
    output logic                       sound_done
);

    // Configuration
    logic [STEP_W-1:0]  step_cfg_reg;
    logic               wide_cfg_reg;
    logic [COUNT_W-1:0] total_cfg_reg;

    // Resampler state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0] index_reg, index_next;
    logic [COUNT_W-1:0] given_reg, given_next;
    logic [CHUNK_W-1:0] offset_reg, offset_next;
    logic [SAMPLE_W-1:0] sample_reg;

    // Hold stage and output register
    logic [SAMPLE_W-1:0] hold_pcm_reg;
    logic [CHUNK_W-1:0]  hold_offset_reg;
    logic                hold_begin_reg;
    logic                hold_done_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_pcm_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_begin_reg;
    logic                out_last_reg;
    logic                out_done_reg;

    logic [STEP_W-1:0]   step_eff;
    logic [COUNT_W-1:0]  phase_gap;
    logic [COUNT_W-1:0]  given_inc;
    logic [SAMPLE_W-1:0] sample_in;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg  <= STEP_RESET;
            wide_cfg_reg  <= WIDE_RESET;
            total_cfg_reg <= TOTAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PHASE_STEP:   step_cfg_reg  <= cfg_data[STEP_W-1:0];
                REG_WIDE_SAMPLES: wide_cfg_reg  <= cfg_data[0];
                REG_OUTPUT_TOTAL: total_cfg_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sample widening and step clamp
    assign sample_in = wide_cfg_reg ? source_bits
                                    : {source_bits[7:0] ^ BYTE_BIAS, 8'h00};
    assign step_eff  = (step_cfg_reg < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP)
                                                          : step_cfg_reg;

    // Due test: integer phase at or behind the source index, mod 2^24
    assign phase_gap = index_reg - phase_reg[PHASE_W-1:FRAC_W];
    assign given_inc = given_reg + 1'b1;

    assign status.more     = (given_reg < total_cfg_reg) && !phase_gap[COUNT_W-1];
    assign status.out_free = !out_valid_reg || out_ready;

    // Next state of the accumulator and counters
    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        given_next  = given_reg;
        offset_next = offset_reg;
        if (cmd.accept && start_sound)
        begin
            phase_next  = '0;
            index_next  = '0;
            given_next  = '0;
            offset_next = '0;
        end
        if (cmd.gen)
        begin
            phase_next  = phase_reg + PHASE_W'(step_eff);
            given_next  = given_inc;
            offset_next = (offset_reg == CHUNK_W'(CHUNK_LEN - 1)) ? '0
                                                                  : offset_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            index_next = index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            index_reg  <= '0;
            given_reg  <= '0;
            offset_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            given_reg  <= given_next;
            offset_reg <= offset_next;
        end
    end

    // Sample latch and hold stage
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample_in;
        end
        if (cmd.gen)
        begin
            hold_pcm_reg    <= sample_reg;
            hold_offset_reg <= offset_reg;
            hold_begin_reg  <= (offset_reg == '0);
            hold_done_reg   <= (given_inc == total_cfg_reg);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_pcm_reg    <= hold_pcm_reg;
            out_offset_reg <= OFFSET_W'(hold_offset_reg);
            out_begin_reg  <= hold_begin_reg;
            out_last_reg   <= cmd.push_last;
            out_done_reg   <= hold_done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pcm_value    = out_pcm_reg;
    assign chunk_offset = out_offset_reg;
    assign chunk_begin  = out_begin_reg;
    assign run_last     = out_last_reg;
    assign sound_done   = out_done_reg;

endmodule
`default_nettype wire

// File: src/nearest_sample_rate_converter_top.sv
`default_nettype none
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     source_bits, start_sound
// output    out        out_valid / out_ready   pcm_value, chunk_offset, chunk_begin,
//                                              run_last, sound_done
// config    in         cfg_write (no wait)     cfg_index, cfg_data
//
// A source sample produces k outputs (0 to 16): an accept step, then the outputs
// through the phase accumulator, then a closing step. The single accumulator/counter
// update per cycle allows one output per cycle while the output register is free.
// A stalled output register holds the run until out_ready frees it.
// Reset clears the accumulator, source index and output count and loads the
// register defaults; no clearing pass is needed.
module nearest_sample_rate_converter_top
    import nsrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SAMPLE_W-1:0]   source_bits,
    input  wire logic                  start_sound,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [SAMPLE_W-1:0] pcm_value,
    output logic [OFFSET_W-1:0]        chunk_offset,
    output logic                       chunk_begin,
    output logic                       run_last,
    output logic                       sound_done,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    nsrc_cmd_t    cmd;
    nsrc_status_t status;

    // Sequencer
    nsrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Accumulator, counters and output register
    nsrc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .source_bits  (source_bits),
        .start_sound  (start_sound),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pcm_value    (pcm_value),
        .chunk_offset (chunk_offset),
        .chunk_begin  (chunk_begin),
        .run_last     (run_last),
        .sound_done   (sound_done)
    );

endmodule
`default_nettype wire

// File: dv/pcm_stream_checker.sv
`default_nettype none
module pcm_stream_checker
    import nsrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [SAMPLE_W-1:0]   source_bits,
    input  wire logic                  start_sound,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [SAMPLE_W-1:0]   pcm_value,
    input  wire logic [OFFSET_W-1:0]   chunk_offset,
    input  wire logic                  chunk_begin,
    input  wire logic                  run_last,
    input  wire logic                  sound_done,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  end_of_test,
    output int                         fault_count,
    output int                         pending,
    output int                         results_checked
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pcm;
        logic [OFFSET_W-1:0]        offset;
        logic                       at_chunk_start;
        logic                       closes_run;
        logic                       ends_sound;
    } pcm_result_t;

    // Results still owed by the block, oldest first
    pcm_result_t pcm_owed_q[$];

    // Register copies
    logic [STEP_W-1:0]  step_reg;
    logic               wide_reg;
    logic [COUNT_W-1:0] total_reg;

    // Resampler state
    logic [PHASE_W-1:0] phase_acc;
    logic [COUNT_W-1:0] sample_idx;
    logic [COUNT_W-1:0] given;

    task automatic note_fault(input string msg);
        fault_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Phase position at or behind the source index (24-bit circular compare)
    function automatic logic phase_due();
        logic [COUNT_W-1:0] lag;
        lag = sample_idx - phase_acc[PHASE_W-1:FRAC_W];
        return !lag[COUNT_W-1];
    endfunction

    // Work out every output one source sample causes
    task automatic predict_run(input logic [SAMPLE_W-1:0] bits, input logic restart);
        logic [SAMPLE_W-1:0] value;
        logic [PHASE_W-1:0]  advance;
        int unsigned         rem;
        int                  produced;
        pcm_result_t         r;
        value = wide_reg ? bits : {bits[7:0] ^ BYTE_BIAS, 8'h00};
        advance = (step_reg < MIN_STEP) ? PHASE_W'(MIN_STEP) : PHASE_W'(step_reg);
        produced = 0;
        if (restart)
        begin
            phase_acc = '0;
            sample_idx = '0;
            given = '0;
        end
        while (produced < MAX_RUN && given < total_reg && phase_due())
        begin
            rem = given % CHUNK_LEN;
            r.pcm = value;
            r.offset = OFFSET_W'(rem);
            r.at_chunk_start = (rem == 0);
            r.closes_run = 1'b0;
            given = given + 1'b1;
            r.ends_sound = (given == total_reg);
            phase_acc = phase_acc + advance;
            pcm_owed_q.push_back(r);
            produced++;
        end
        if (produced > 0)
            pcm_owed_q[pcm_owed_q.size()-1].closes_run = 1'b1;
        sample_idx = sample_idx + 1'b1;
    endtask

    // Watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        pcm_result_t seen;
        pcm_result_t want;
        if (!rst_n)
        begin
            step_reg = STEP_RESET;
            wide_reg = WIDE_RESET;
            total_reg = TOTAL_RESET;
            phase_acc = '0;
            sample_idx = '0;
            given = '0;
            pcm_owed_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:   step_reg = cfg_data[STEP_W-1:0];
                    REG_WIDE_SAMPLES: wide_reg = cfg_data[0];
                    REG_OUTPUT_TOTAL: total_reg = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            // output transaction: compare with the oldest owed result
            if (out_valid && out_ready)
            begin
                seen = {pcm_value, chunk_offset, chunk_begin, run_last, sound_done};
                results_checked++;
                if (pcm_owed_q.size() == 0)
                    note_fault($sformatf("unexpected output pcm %0d offset %0d",
                                         seen.pcm, seen.offset));
                else
                begin
                    want = pcm_owed_q.pop_front();
                    if (seen !== want)
                        note_fault($sformatf({"pcm %0d/%0d offset %0d/%0d begin %b/%b ",
                                              "last %b/%b done %b/%b (got/exp)"},
                                             seen.pcm, want.pcm, seen.offset, want.offset,
                                             seen.at_chunk_start, want.at_chunk_start,
                                             seen.closes_run, want.closes_run,
                                             seen.ends_sound, want.ends_sound));
                end
            end

            // input transaction: extend the owed list
            if (in_valid && in_ready)
                predict_run(source_bits, start_sound);

            pending = pcm_owed_q.size();
        end
    end

    // Anything still owed when the test ends is a failure
    always @(posedge end_of_test)
    begin
        if (pcm_owed_q.size() != 0)
            note_fault($sformatf("%0d outputs never arrived", pcm_owed_q.size()));
    end

endmodule
`default_nettype wire

// File: dv/nearest_sample_rate_converter_top_tb.sv
`default_nettype none
module nearest_sample_rate_converter_top_tb;
    import nsrc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [SAMPLE_W-1:0]         source_bits = '0;
    logic                        start_sound = 1'b0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]  pcm_value;
    logic [OFFSET_W-1:0]         chunk_offset;
    logic                        chunk_begin;
    logic                        run_last;
    logic                        sound_done;
    logic                        cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_data = '0;

    logic end_of_test = 1'b0;
    int   fault_count;
    int   pending;
    int   results_checked;

    // stimulus controls
    bit calm = 1'b0;
    bit burst_req = 1'b0;
    int hold_left = 0;
    int samples_sent = 0;
    int phases_run = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nearest_sample_rate_converter_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_bits  (source_bits),
        .start_sound  (start_sound),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pcm_value    (pcm_value),
        .chunk_offset (chunk_offset),
        .chunk_begin  (chunk_begin),
        .run_last     (run_last),
        .sound_done   (sound_done),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pcm_stream_checker pcm_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .source_bits     (source_bits),
        .start_sound     (start_sound),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pcm_value       (pcm_value),
        .chunk_offset    (chunk_offset),
        .chunk_begin     (chunk_begin),
        .run_last        (run_last),
        .sound_done      (sound_done),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .end_of_test     (end_of_test),
        .fault_count     (fault_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Output side: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin : receiver
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (burst_req)
        begin
            burst_req = 1'b0;
            hold_left = 300;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && (calm || $urandom_range(99) >= 36);
    end

    // One input transaction, with an optional random gap in front
    task automatic send_sample(input logic [SAMPLE_W-1:0] bits, input logic restart);
        if (!calm && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 36);
        end
        in_valid <= 1'b1;
        source_bits <= bits;
        start_sound <= restart;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    // Stop offering, drain every owed output, then let the block go quiet
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (24) @(posedge clk);
    endtask

    // Register writes go back to back; cfg_done drops the enable
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic cfg_done();
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] total;
        logic               fresh;
        int                 phase_len;
        int                 pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: count already reached, nothing comes out
        send_sample(16'h1234, 1'b1);
        send_sample(16'hEDCB, 1'b0);
        settle();

        // equal rates, 16-bit samples at the extremes
        cfg_put(REG_OUTPUT_TOTAL, 24'd12);
        cfg_done();
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h5A5A, 1'b0);
        settle();

        // 8-bit samples, step of zero acts as the minimum, unknown register ignored;
        // third sample hits the count, fourth emits nothing
        cfg_put(REG_WIDE_SAMPLES, 24'h000000);
        cfg_put(REG_PHASE_STEP, 24'h000000);
        cfg_put(REG_UNUSED, 24'hFFFFFF);
        cfg_put(REG_OUTPUT_TOTAL, 24'd40);
        cfg_done();
        send_sample(16'hFF00, 1'b1);
        send_sample(16'h00FF, 1'b0);
        send_sample(16'h1280, 1'b0);
        send_sample(16'hAB7F, 1'b0);
        settle();

        // raising the total leaves the phase behind: a capped run, then catch-up
        cfg_put(REG_OUTPUT_TOTAL, 24'd60);
        cfg_done();
        send_sample(16'h3C3C, 1'b0);
        send_sample(16'hC3C3, 1'b0);
        settle();

        // largest step: most samples are skipped
        cfg_put(REG_PHASE_STEP, 24'h000FFF);
        cfg_put(REG_WIDE_SAMPLES, 24'h000001);
        cfg_put(REG_OUTPUT_TOTAL, 24'd8);
        cfg_done();
        for (int i = 0; i < 8; i++)
            send_sample(SAMPLE_W'($urandom), i == 0);
        settle();

        // random register settings, each followed by a run of samples
        while (samples_sent < 440)
        begin
            phases_run++;
            calm = (phases_run == 2);
            pick = $urandom_range(9);
            case (pick)
                0:       step = STEP_W'($urandom_range(15));
                1:       step = STEP_W'(16);
                2:       step = STEP_W'(4095);
                3:       step = STEP_W'(256);
                4:       step = STEP_W'(128);
                5:       step = STEP_W'($urandom_range(601, 4095));
                default: step = STEP_W'($urandom_range(16, 600));
            endcase
            pick = $urandom_range(7);
            case (pick)
                0:       total = '0;
                1:       total = '1;
                2:       total = COUNT_W'($urandom_range(1, 30));
                3:       total = COUNT_W'($urandom);
                default: total = COUNT_W'($urandom_range(31, 1500));
            endcase
            phase_len = $urandom_range(8, 40);
            fresh = ($urandom_range(3) != 0);

            // long sound at the minimum step: crosses chunk boundaries and
            // fills the block while the output side holds off
            if (phases_run == 4)
            begin
                step = STEP_W'(MIN_STEP);
                total = '1;
                phase_len = 80;
                fresh = 1'b1;
            end

            cfg_put(REG_PHASE_STEP, {(CFG_W-STEP_W)'($urandom), step});
            cfg_put(REG_WIDE_SAMPLES, {(CFG_W-1)'($urandom), 1'($urandom)});
            if (phases_run == 4 || $urandom_range(3) != 0)
                cfg_put(REG_OUTPUT_TOTAL, total);
            cfg_done();

            if (phases_run == 4)
                burst_req = 1'b1;
            for (int i = 0; i < phase_len; i++)
                send_sample(SAMPLE_W'($urandom),
                            (i == 0 && fresh) || $urandom_range(29) == 0);
            settle();
        end
        calm = 1'b0;

        end_of_test = 1'b1;
        @(posedge clk);
        $display("Run covered %0d source samples over %0d register settings, %0d outputs compared",
                 samples_sent, phases_run + 5, results_checked);
        $display("Steps 0 to 4095, both sample widths, capped and lagging runs, chunk wrap, long stall");
        if (fault_count == 0)
            $display("nearest_sample_rate_converter_top verification clean");
        else
            $display("nearest_sample_rate_converter_top verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TIMEOUT: run did not finish");
        $display("nearest_sample_rate_converter_top verification failed");
        $finish;
    end

endmodule
`default_nettype wire
